// ----- design/olar_pkg.sv -----
// ----------------------------------------------------------------------------
// olar_pkg: shared types and constants for the ordered list core
// Payload structs, status codes and the control/status bundles that run
// between the controller and the datapath.
// ----------------------------------------------------------------------------
package olar_pkg;

  localparam int CAPACITY = 32;
  localparam int AW       = $clog2(CAPACITY);
  localparam int FILL_W   = $clog2(CAPACITY + 1);

  localparam logic [1:0] OP_APPEND = 2'd0;
  localparam logic [1:0] OP_REMOVE = 2'd1;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_FULL     = 2'd1;
  localparam logic [1:0] ST_NOTFOUND = 2'd2;
  localparam logic [1:0] ST_EMPTY    = 2'd3;

  typedef struct packed {
    logic [1:0]         op;
    logic signed [31:0] value;
  } olar_in_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] item;
    logic               last;
    logic [5:0]         entries;
  } olar_out_t;

  // controller -> datapath
  typedef struct packed {
    logic       start;      // capture search value, rewind index
    logic       append;     // write tail slot, bump fill
    logic       scan;       // one remove search/compact step
    logic       drop;       // remove finished with a hit: shrink fill
    logic       advance;    // dump transfer taken: next entry
    logic       show_item;  // drive the read data onto item
    logic       last;
    logic [1:0] status;
  } olar_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic full;
    logic empty;
    logic found;
    logic scan_done;
    logic last;
  } olar_sts_t;

endpackage

// ----- design/olar_dp.sv -----
// ----------------------------------------------------------------------------
// olar_dp: list store and datapath
// Slot memory with one write and one registered read port, fill count,
// walk index and the search/compact logic for remove.
// ----------------------------------------------------------------------------
module olar_dp (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  olar_pkg::olar_cmd_t cmd_i,
  input  logic signed [31:0]  value_i,
  output olar_pkg::olar_sts_t sts_o,
  output olar_pkg::olar_out_t out_o
);
  import olar_pkg::*;

  logic [31:0]       mem [CAPACITY];
  logic [31:0]       rd_data_q;
  logic [AW-1:0]     rd_addr;
  logic              wr_en;
  logic [AW-1:0]     wr_addr;
  logic [31:0]       wr_data;

  logic [FILL_W-1:0] fill_q, fill_d;
  logic [FILL_W-1:0] idx_q, idx_d;
  logic [FILL_W-1:0] idx_inc;
  logic [FILL_W-1:0] shift_idx;
  logic [31:0]       val_q;
  logic              found_q, found_d;
  logic              have_data;
  logic              hit;
  logic              shift;

  assign idx_inc   = idx_q + FILL_W'(1);
  // read data during a scan belongs to idx-1; a shifted entry lands at idx-2
  assign shift_idx = idx_q - FILL_W'(2);
  assign have_data = (idx_q != '0);
  assign hit       = cmd_i.scan && have_data && !found_q && (rd_data_q == val_q);
  assign shift     = cmd_i.scan && have_data && found_q;

  // read ahead on a dump transfer so the next entry is ready in the following cycle
  assign rd_addr = cmd_i.advance ? idx_inc[AW-1:0] : idx_q[AW-1:0];

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = fill_q[AW-1:0];
    wr_data = value_i;
    if (cmd_i.append) begin
      wr_en = 1'b1;
    end else if (shift) begin
      wr_en   = 1'b1;
      wr_addr = shift_idx[AW-1:0];
      wr_data = rd_data_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_q <= mem[rd_addr];
    if (cmd_i.start) begin
      val_q <= value_i;
    end
  end

  always_comb begin
    fill_d  = fill_q;
    idx_d   = idx_q;
    found_d = found_q;
    if (cmd_i.append) fill_d = fill_q + FILL_W'(1);
    if (cmd_i.drop)   fill_d = fill_q - FILL_W'(1);
    if (cmd_i.start) begin
      idx_d   = '0;
      found_d = 1'b0;
    end else if (cmd_i.scan || cmd_i.advance) begin
      idx_d = idx_inc;
    end
    if (hit) found_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q  <= '0;
      idx_q   <= '0;
      found_q <= 1'b0;
    end else begin
      fill_q  <= fill_d;
      idx_q   <= idx_d;
      found_q <= found_d;
    end
  end

  assign sts_o.full      = (fill_q == FILL_W'(CAPACITY));
  assign sts_o.empty     = (fill_q == '0);
  assign sts_o.found     = found_q | hit;
  assign sts_o.scan_done = (idx_q == fill_q);
  assign sts_o.last      = (idx_inc == fill_q);

  assign out_o.status  = cmd_i.status;
  assign out_o.item    = cmd_i.show_item ? rd_data_q : '0;
  assign out_o.last    = cmd_i.last;
  assign out_o.entries = 6'(fill_q);

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= FILL_W'(CAPACITY))
    else $error("fill count above capacity");

  a_append_grow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.append |=> fill_q == FILL_W'($past(fill_q) + FILL_W'(1)))
    else $error("append did not grow the list by one");

  a_drop_shrink: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.drop |=> fill_q == FILL_W'($past(fill_q) - FILL_W'(1)))
    else $error("remove did not shrink the list by one");

endmodule

// ----- design/olar_ctrl.sv -----
// ----------------------------------------------------------------------------
// olar_ctrl: operation sequencer
// Decodes each accepted item and steps the datapath through append,
// remove search/compact and dump, then presents the results.
// ----------------------------------------------------------------------------
module olar_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [1:0]          op_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  input  olar_pkg::olar_sts_t sts_i,
  output olar_pkg::olar_cmd_t cmd_o
);
  import olar_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_PRIME,
    S_DUMP,
    S_RESP
  } state_e;

  state_e     state_q, state_d;
  logic [1:0] status_q, status_d;

  always_comb begin
    state_d       = state_q;
    status_d      = status_q;
    in_ready_o    = 1'b0;
    out_valid_o   = 1'b0;
    cmd_o         = '0;
    cmd_o.status  = status_q;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          case (op_i)
            OP_APPEND: begin
              if (sts_i.full) begin
                status_d = ST_FULL;
              end else begin
                cmd_o.append = 1'b1;
                status_d     = ST_OK;
              end
              state_d = S_RESP;
            end
            OP_REMOVE: begin
              cmd_o.start = 1'b1;
              state_d     = S_SCAN;
            end
            default: begin
              // high op bit set: dump
              if (sts_i.empty) begin
                status_d = ST_EMPTY;
                state_d  = S_RESP;
              end else begin
                cmd_o.start = 1'b1;
                state_d     = S_PRIME;
              end
            end
          endcase
        end
      end
      S_SCAN: begin
        cmd_o.scan = 1'b1;
        if (sts_i.scan_done) begin
          cmd_o.drop = sts_i.found;
          status_d   = sts_i.found ? ST_OK : ST_NOTFOUND;
          state_d    = S_RESP;
        end
      end
      S_PRIME: begin
        state_d = S_DUMP;
      end
      S_DUMP: begin
        out_valid_o     = 1'b1;
        cmd_o.show_item = 1'b1;
        cmd_o.last      = sts_i.last;
        cmd_o.status    = ST_OK;
        if (out_ready_i) begin
          cmd_o.advance = 1'b1;
          if (sts_i.last) state_d = S_IDLE;
        end
      end
      S_RESP: begin
        out_valid_o = 1'b1;
        cmd_o.last  = 1'b1;
        if (out_ready_i) state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      status_q <= ST_OK;
    end else begin
      state_q  <= state_d;
      status_q <= status_d;
    end
  end

  a_one_side: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o))
    else $error("input taken while a result is pending");

  a_scan_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN && sts_i.scan_done) |=> state_q == S_RESP)
    else $error("remove scan did not hand over to the response");

  a_drop_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.drop |-> (state_q == S_SCAN && sts_i.found && !sts_i.empty))
    else $error("entry dropped without a match");

endmodule

// ----- design/ordered_list_append_remove_core.sv -----
// ----------------------------------------------------------------------------
// ordered_list_append_remove_core: bounded ordered list of 32-bit values
// Append at the tail, remove the first equal entry, dump in list order.
// ----------------------------------------------------------------------------
// The list lives in a CAPACITY-entry slot memory with one write port and one
// registered read port, kept in order from slot 0 up to fill-1. Each input
// transfer is one operation; the core takes the next one only after the last
// result transfer of the current one. Append (op 0) writes the tail slot and
// returns one result, or status full when every slot is used. Remove (op 1)
// walks the memory from the head, one slot per cycle through the read port,
// and once the first match is seen moves each later entry down one slot on
// the write port in the same walk, then returns one result, ok or not found.
// Dump (op 2, and reserved op 3) streams every entry in order with last set
// on the final one, after a prime state for the registered read, one result
// transfer per cycle while the sink is ready; an empty list gives one result
// with status empty. The fill count alone sets the length of remove and
// dump. Item is zero except in dump results, and entries always reports the
// count after the operation. Slot contents need no reset since only data
// from slots below the fill count is ever used.
// ----------------------------------------------------------------------------
module ordered_list_append_remove_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  olar_pkg::olar_in_t  in_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  output olar_pkg::olar_out_t out_o,
  output logic                out_valid_o,
  input  logic                out_ready_i
);
  import olar_pkg::*;

  // command and status bundles between sequencer and datapath
  olar_cmd_t cmd;
  olar_sts_t sts;

  // sequencer: owns both handshakes and the status code of each transfer
  olar_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .op_i        (in_i.op),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // datapath: slot memory, fill count, walk index and result payload
  olar_dp u_dp (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cmd_i   (cmd),
    .value_i (in_i.value),
    .sts_o   (sts),
    .out_o   (out_o)
  );

  // a result is never offered while the core is also taking input
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o))
    else $error("input and output sides active together");

  // append, remove and an empty-list dump return a single transfer, so last is set
  a_single_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !cmd.show_item) |-> out_o.last)
    else $error("single result without last");

  // a dump result never reports an entry count of zero
  a_dump_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && cmd.show_item) |-> (out_o.status == ST_OK && !sts.empty))
    else $error("dump entry emitted from an empty list");

endmodule

// ----- verif/olar_list_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// olar_list_checker: scoreboard for the ordered list core
// Watches both channels. Every accepted operation is run through a shadow
// copy of the list, and the results that it owes are queued. Every accepted
// result is then checked field by field against the oldest one in the queue.
// ----------------------------------------------------------------------------
module olar_list_checker (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  olar_pkg::olar_in_t  in_i,
  input  logic                in_valid_i,
  input  logic                in_ready_i,
  input  olar_pkg::olar_out_t out_i,
  input  logic                out_valid_i,
  input  logic                out_ready_i,
  output int unsigned         owed_o,
  output int unsigned         errors_o
);

  import olar_pkg::*;

  localparam int unsigned PRINT_CAP = 40;

  logic [31:0] shadow_slots [CAPACITY];
  int unsigned shadow_fill;
  olar_out_t   owed_results [$];
  int unsigned mismatches = 0;

  assign errors_o = mismatches;

  task automatic report_mismatch(input string what);
    mismatches++;
    if (mismatches <= PRINT_CAP) $display("[%0t] olar_list_checker: %s", $time, what);
  endtask

  // entries always carries the count after the operation
  function automatic void owe_result(input logic [1:0] st, input logic [31:0] item,
                                     input logic last);
    olar_out_t r;
    r.status  = st;
    r.item    = item;
    r.last    = last;
    r.entries = 6'(shadow_fill);
    owed_results.push_back(r);
  endfunction

  task automatic apply_list_op(input olar_in_t req);
    int unsigned hit;
    if (req.op[1]) begin
      // dump; the reserved code shares the high op bit
      if (shadow_fill == 0) begin
        owe_result(ST_EMPTY, '0, 1'b1);
      end else begin
        for (int unsigned k = 0; k < shadow_fill; k++)
          owe_result(ST_OK, shadow_slots[k], (k + 1) == shadow_fill);
      end
    end else if (req.op == OP_APPEND) begin
      if (shadow_fill >= CAPACITY) begin
        owe_result(ST_FULL, '0, 1'b1);
      end else begin
        shadow_slots[shadow_fill] = req.value;
        shadow_fill++;
        owe_result(ST_OK, '0, 1'b1);
      end
    end else begin
      // first match from the head, full 32-bit compare
      hit = shadow_fill;
      for (int unsigned k = 0; k < shadow_fill; k++)
        if (hit == shadow_fill && shadow_slots[k] == req.value) hit = k;
      if (hit == shadow_fill) begin
        owe_result(ST_NOTFOUND, '0, 1'b1);
      end else begin
        for (int unsigned k = hit; k + 1 < shadow_fill; k++)
          shadow_slots[k] = shadow_slots[k + 1];
        shadow_fill--;
        owe_result(ST_OK, '0, 1'b1);
      end
    end
  endtask

  task automatic check_result(input olar_out_t got);
    olar_out_t want;
    if (owed_results.size() == 0) begin
      report_mismatch($sformatf("unexpected result status=%0d item=%h last=%b entries=%0d",
                                got.status, got.item, got.last, got.entries));
      return;
    end
    want = owed_results.pop_front();
    if (got.status !== want.status)
      report_mismatch($sformatf("status got %0d want %0d", got.status, want.status));
    if (got.item !== want.item)
      report_mismatch($sformatf("item got %h want %h", got.item, want.item));
    if (got.last !== want.last)
      report_mismatch($sformatf("last got %b want %b", got.last, want.last));
    if (got.entries !== want.entries)
      report_mismatch($sformatf("entries got %0d want %0d", got.entries, want.entries));
  endtask

  // operation first: a result never shares an edge with its own request
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      owed_results.delete();
      shadow_fill = 0;
      owed_o <= 0;
    end else begin
      if (in_valid_i && in_ready_i) apply_list_op(in_i);
      if (out_valid_i && out_ready_i) check_result(out_i);
      owed_o <= owed_results.size();
    end
  end

endmodule

// ----- verif/tb_ordered_list_append_remove_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_ordered_list_append_remove_core: testbench for the ordered list core
// A short directed run over empty, duplicate, extreme and miss cases, then
// random segments that grow the list to full, shrink it and mix operations,
// with bursty requests and a sink that stalls on its own pattern.
// ----------------------------------------------------------------------------
module tb_ordered_list_append_remove_core;

  import olar_pkg::*;

  localparam int unsigned CLK_PERIOD     = 10;
  localparam int unsigned RESET_CYCLES   = 9;
  localparam int unsigned RANDOM_ITEMS   = 310;
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  // leave room for a full-list remove after drain
  localparam int unsigned TAIL_CYCLES    = CAPACITY + 8;

  // op codes beyond what the package names
  localparam logic [1:0] OP_DUMP = 2'd2;
  localparam logic [1:0] OP_RESV = 2'd3;

  typedef enum logic [1:0] {SEG_GROW, SEG_SHRINK, SEG_MIX} seg_kind_e;
  typedef enum logic [1:0] {SINK_OPEN, SINK_DROPS, SINK_HOLDS} sink_mode_e;

  logic      clk_i     = 1'b0;
  logic      rst_ni    = 1'b0;
  olar_in_t  in_pl     = '0;
  logic      in_valid  = 1'b0;
  logic      in_ready;
  olar_out_t out_pl;
  logic      out_valid;
  logic      out_ready = 1'b0;

  int unsigned owed;
  int unsigned err_cnt;

  int unsigned n_sent     = 0;
  int unsigned burst_left = 0;
  logic [31:0] value_pool [8];

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  ordered_list_append_remove_core u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_pl),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .out_o      (out_pl),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready)
  );

  olar_list_checker u_chk (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_pl),
    .in_valid_i (in_valid),
    .in_ready_i (in_ready),
    .out_i      (out_pl),
    .out_valid_i(out_valid),
    .out_ready_i(out_ready),
    .owed_o     (owed),
    .errors_o   (err_cnt)
  );

  // --------------------------------------------------------------------------
  // Sink: cycles through open stretches, random drops and long
  // holds. Each mode lasts a random number of cycles, so stalls land on the
  // first, middle and last transfer of a dump alike.
  // --------------------------------------------------------------------------
  sink_mode_e  sink_mode = SINK_OPEN;
  int unsigned sink_left = 0;
  int unsigned hold_left = 0;

  always @(posedge clk_i) begin
    if (sink_left == 0) begin
      sink_mode = sink_mode_e'($urandom_range(2, 0));
      sink_left = $urandom_range(160, 20);
    end
    sink_left--;
    case (sink_mode)
      SINK_OPEN: begin
        out_ready <= 1'b1;
      end
      SINK_DROPS: begin
        out_ready <= ($urandom_range(3, 0) != 0);
      end
      default: begin
        if (hold_left != 0) begin
          hold_left--;
          out_ready <= 1'b0;
        end else if ($urandom_range(5, 0) == 0) begin
          hold_left = $urandom_range(12, 1);
          out_ready <= 1'b0;
        end else begin
          out_ready <= 1'b1;
        end
      end
    endcase
  end

  // --------------------------------------------------------------------------
  // Watchdog: any transfer on either side restarts the count. The longest
  // legal quiet stretch is a full-list remove plus a sink hold plus a sender
  // gap, well under the limit.
  // --------------------------------------------------------------------------
  int unsigned quiet_cycles = 0;

  always @(posedge clk_i) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("tb_ordered_list_append_remove_core: done, errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // --------------------------------------------------------------------------
  // Request side. Called just after a rising edge: the payload and valid go
  // out with one nonblocking write each, and valid is left high across
  // back-to-back transfers. At the end of a burst valid drops for a gap.
  // --------------------------------------------------------------------------
  task automatic push_op(input logic [1:0] op, input logic [31:0] value);
    olar_in_t req;
    req.op    = op;
    req.value = value;
    in_pl    <= req;
    in_valid <= 1'b1;
    @(posedge clk_i);
    while (!in_ready) @(posedge clk_i);
    n_sent++;
    if (burst_left > 1) begin
      burst_left--;
    end else begin
      in_valid <= 1'b0;
      repeat ($urandom_range(8, 1)) @(posedge clk_i);
      // mostly short bursts, now and then a long run with no gaps at all
      burst_left = ($urandom_range(4, 0) == 0) ? $urandom_range(60, 25)
                                               : $urandom_range(10, 1);
    end
  endtask

  // Hold requests off until the scoreboard owes nothing. The count from the
  // checker is registered, so look only from the next edge on.
  task automatic park_until_drained();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (owed != 0) @(posedge clk_i);
  endtask

  // Pool values make removes hit and create duplicates; the rest are misses.
  function automatic logic [31:0] pick_value();
    if ($urandom_range(3, 0) != 0) return value_pool[$urandom_range(7, 0)];
    return $urandom;
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus and verdict
  // --------------------------------------------------------------------------
  initial begin
    seg_kind_e   seg;
    int unsigned seg_len;
    int unsigned roll;
    int unsigned rand_base;

    value_pool[0] = 32'h8000_0000;
    value_pool[1] = 32'h7fff_ffff;
    value_pool[2] = 32'h0000_0000;
    value_pool[3] = 32'hffff_ffff;
    for (int k = 4; k < 8; k++) value_pool[k] = $urandom;
    burst_left = $urandom_range(10, 1);

    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty list: dump, reserved code as dump, remove miss
    push_op(OP_DUMP, $urandom);
    push_op(OP_RESV, $urandom);
    push_op(OP_REMOVE, 32'h0000_0000);
    // extremes, alternating bit patterns, a duplicate pair
    push_op(OP_APPEND, 32'h8000_0000);
    push_op(OP_APPEND, 32'h7fff_ffff);
    push_op(OP_APPEND, 32'h0000_0000);
    push_op(OP_APPEND, 32'hffff_ffff);
    push_op(OP_APPEND, 32'h0000_0005);
    push_op(OP_APPEND, 32'h5555_5555);
    push_op(OP_APPEND, 32'h0000_0005);
    push_op(OP_APPEND, 32'haaaa_aaaa);
    push_op(OP_DUMP, 32'hffff_ffff);
    // duplicate: only the one nearer the head goes
    push_op(OP_REMOVE, 32'h0000_0005);
    push_op(OP_DUMP, 32'h0000_0000);
    // miss by one bit, absent value, then head and tail removes
    push_op(OP_REMOVE, 32'h7fff_fffe);
    push_op(OP_REMOVE, 32'h1234_5678);
    push_op(OP_REMOVE, 32'h8000_0000);
    push_op(OP_REMOVE, 32'haaaa_aaaa);
    push_op(OP_RESV, 32'h0000_0000);
    park_until_drained();

    // First segment is long and mostly appends, so append-when-full is likely hit
    // early; later segments are picked at random.
    rand_base = n_sent;
    seg       = SEG_GROW;
    seg_len   = CAPACITY + 4;
    while (n_sent - rand_base < RANDOM_ITEMS) begin
      repeat (seg_len) begin
        roll = $urandom_range(99, 0);
        case (seg)
          SEG_GROW: begin
            if (roll < 85)      push_op(OP_APPEND, pick_value());
            else if (roll < 95) push_op(OP_DUMP, $urandom);
            else                push_op(OP_REMOVE, pick_value());
          end
          SEG_SHRINK: begin
            if (roll < 80)      push_op(OP_REMOVE, pick_value());
            else if (roll < 90) push_op(OP_DUMP, $urandom);
            else                push_op(OP_APPEND, pick_value());
          end
          default: begin
            if (roll < 35)      push_op(OP_APPEND, pick_value());
            else if (roll < 70) push_op(OP_REMOVE, pick_value());
            else if (roll < 93) push_op(OP_DUMP, $urandom);
            else                push_op(OP_RESV, $urandom);
          end
        endcase
      end
      if ($urandom_range(3, 0) == 0) park_until_drained();
      seg     = seg_kind_e'($urandom_range(2, 0));
      seg_len = $urandom_range(40, 8);
    end

    park_until_drained();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("tb_ordered_list_append_remove_core: done, clean");
    end else begin
      $display("tb_ordered_list_append_remove_core: done, errors");
    end
    $finish;
  end

endmodule
